// File: design/aocs_pkg.sv
// aocs_pkg: shared widths, fixed-point constants, codes and types of the audio output clip stage
// no dependencies; imported by every module of the block

package aocs_pkg;

    // input field widths
    localparam int SAMPLE_W  = 27;
    localparam int GAIN_W    = 16;
    localparam int MODE_W    = 2;
    localparam int S_TDATA_W = ((3 * SAMPLE_W + GAIN_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME_GAIN = 2'd1;
    localparam logic [GAIN_W-1:0]      VOLUME_RESET    = 16'd16384;

    // converter datapath widths
    localparam int MAG_W     = SAMPLE_W;        // |sample| up to 2^26
    localparam int A_W       = 28;              // volume scaled magnitude
    localparam int C_W       = 23;              // clipped magnitude, always below 2^23
    localparam int VOL_SHIFT = 14;              // Q2.14 volume
    localparam int MC_W      = 28;              // serial multiplier multiplicand
    localparam int ML_W      = 24;              // serial multiplier multiplier
    localparam int PROD_W    = MC_W + ML_W;
    localparam int DEN_W     = 29;              // divider denominator
    localparam int Q_W       = 23;              // divider quotient
    localparam int V_W       = 39;              // clipped magnitude times fade
    localparam int VLO_W     = 19;
    localparam int VHI_W     = V_W - VLO_W;

    // Q.23 constants of the soft clip curve
    localparam logic [A_W-1:0]   KNEE_Q23   = 28'd7957433;
    localparam logic [A_W-1:0]   OFFSET_Q23 = 28'd7704013;
    localparam logic [ML_W-1:0]  CEIL_Q23   = 24'd8220836;
    localparam logic [DEN_W-1:0] SOFT_Q23   = 29'd8389;

    // peak meter
    localparam int PEAK_W = 26;
    localparam logic [PEAK_W-1:0] LED_Q23 = 26'd7549747;

    typedef enum logic [MODE_W-1:0] {
        MODE_STEREO   = 2'd0,
        MODE_LINE     = 2'd1,
        MODE_BALANCED = 2'd2,
        MODE_MONITOR  = 2'd3
    } output_mode_t;

    typedef enum logic [2:0] {
        LANE_IDLE,
        LANE_MUL_VOL,
        LANE_KNEE,
        LANE_MUL_CEIL,
        LANE_DIV,
        LANE_MUL_FADE,
        LANE_SCALE_MUL,
        LANE_SCALE_SUM
    } lane_state_t;

    typedef struct packed {
        logic busy;
        logic clip;
    } lane_status_t;

endpackage

// File: design/audio_output_clip_stage.sv
// audio_output_clip_stage: top level; two conversion lanes run in parallel, then output routing
// each lane runs its 24-step serial multiplier in two passes, or three with its 23-step divider
// in series when the lane clips; a new input beat is taken only once both lanes are done and
// the result beat is loaded; the next input overlaps the output wait
// reset: synchronous active low; mode stereo, volume unity, peak, count and led cleared
// depends on aocs_pkg, aocs_convert and aocs_peak_meter

module audio_output_clip_stage import aocs_pkg::*; #(
    parameter int WINDOW_BITS = 9,
    parameter int OUT_WIDTH   = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // config write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // tdata: left_sample, right_sample, monitor_sample, fade_gain, zero pad
    input  logic [S_TDATA_W-1:0]       s_tdata,
    // output stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // tdata: left_out, right_out, zero pad
    output logic [((2*OUT_WIDTH+7)/8)*8-1:0] m_tdata,
    // tuser: clipped, peak_led
    output logic [1:0]                 m_tuser
);

    localparam int M_TDATA_W = ((2 * OUT_WIDTH + 7) / 8) * 8;

    output_mode_t              mode_reg;
    logic [GAIN_W-1:0]         vol_reg;
    logic                      busy_reg;
    logic                      m_valid_reg;
    logic signed [OUT_WIDTH-1:0] m_left_reg, m_right_reg;
    logic                      m_clip_reg, m_led_reg;

    logic                      accept;
    logic                      finish;
    logic signed [SAMPLE_W-1:0] left_sample, right_sample, monitor_sample;
    logic signed [SAMPLE_W-1:0] lane_a_sample;
    logic [GAIN_W-1:0]         fade_gain;
    lane_status_t              lane_a_status, lane_b_status;
    logic signed [OUT_WIDTH-1:0] lane_a_value, lane_b_value;
    logic signed [OUT_WIDTH-1:0] left_route, right_route;
    logic                      led;

    assign left_sample    = s_tdata[0 +: SAMPLE_W];
    assign right_sample   = s_tdata[SAMPLE_W +: SAMPLE_W];
    assign monitor_sample = s_tdata[2*SAMPLE_W +: SAMPLE_W];
    assign fade_gain      = s_tdata[3*SAMPLE_W +: GAIN_W];

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && !busy_reg;
    assign finish   = busy_reg && !lane_a_status.busy && !lane_b_status.busy
                      && (!m_valid_reg || m_tready);

    // in monitor mode lane a converts the monitor sample and its clip is reported
    assign lane_a_sample = (mode_reg == MODE_MONITOR) ? monitor_sample : left_sample;

    aocs_convert #(.OUT_W(OUT_WIDTH)) u_lane_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .sample    (lane_a_sample),
        .vol_gain  (vol_reg),
        .fade_gain (fade_gain),
        .status    (lane_a_status),
        .value     (lane_a_value)
    );

    aocs_convert #(.OUT_W(OUT_WIDTH)) u_lane_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .sample    (right_sample),
        .vol_gain  (vol_reg),
        .fade_gain (fade_gain),
        .status    (lane_b_status),
        .value     (lane_b_value)
    );

    aocs_peak_meter #(.WINDOW_BITS(WINDOW_BITS)) u_peak (
        .aclk    (aclk),
        .aresetn (aresetn),
        .strobe  (accept),
        .sample  (left_sample),
        .led     (led)
    );

    always_comb begin
        left_route  = lane_a_value;
        right_route = lane_b_value;
        unique case (mode_reg)
            MODE_STEREO:   ;
            MODE_LINE: begin
                left_route  = lane_a_value >>> 1;
                right_route = lane_b_value >>> 1;
            end
            MODE_BALANCED: right_route = OUT_WIDTH'(0) - lane_a_value;
            MODE_MONITOR:  ;
            default:       ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_STEREO;
            vol_reg  <= VOLUME_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_OUTPUT_MODE: mode_reg <= output_mode_t'(cfg_data[MODE_W-1:0]);
                CFG_VOLUME_GAIN: vol_reg  <= cfg_data[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (finish) begin
                busy_reg <= 1'b0;
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result beat register, loaded when both lanes are done and the slot is free
    always_ff @(posedge aclk) begin
        if (finish) begin
            m_left_reg  <= left_route;
            m_right_reg <= right_route;
            m_clip_reg  <= lane_a_status.clip;
            m_led_reg   <= led;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = M_TDATA_W'({m_right_reg, m_left_reg});
    assign m_tuser   = {m_led_reg, m_clip_reg};

endmodule

// File: design/aocs_serial_mult.sv
// aocs_serial_mult: radix-2 shift-add multiplier, one multiplier bit per cycle
// depends on aocs_pkg for operand widths

module aocs_serial_mult import aocs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MC_W-1:0]   mcand,
    input  logic [ML_W-1:0]   mlier,
    output logic              busy,
    output logic [PROD_W-1:0] product
);

    localparam int CNT_W = $clog2(ML_W + 1);

    logic [PROD_W-1:0] p_reg, p_next;
    logic [MC_W-1:0]   mc_reg, mc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [MC_W:0]     sum;

    // upper half accumulates, multiplier bits shift out of the low end
    assign sum = {1'b0, p_reg[PROD_W-1:ML_W]} + (p_reg[0] ? {1'b0, mc_reg} : '0);

    always_comb begin
        p_next    = p_reg;
        mc_next   = mc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            p_next    = {{MC_W{1'b0}}, mlier};
            mc_next   = mcand;
            cnt_next  = CNT_W'(ML_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            p_next    = {sum, p_reg[ML_W-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg  <= p_next;
        mc_reg <= mc_next;
    end

    assign busy    = busy_reg;
    assign product = p_reg;

endmodule

// File: design/aocs_serial_div.sv
// aocs_serial_div: restoring divider, one quotient bit per cycle
// depends on aocs_pkg; expects the numerator's upper part below the denominator

module aocs_serial_div import aocs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] num,
    input  logic [DEN_W-1:0]  den,
    output logic              busy,
    output logic [Q_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    // numerator low bits shift out of the top of q_reg into the remainder, quotient bits enter below
    assign shifted = {rem_reg, q_reg[Q_W-1]};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign diff    = shifted - {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = num[Q_W +: DEN_W];
            q_next    = num[Q_W-1:0];
            den_next  = den;
            cnt_next  = CNT_W'(Q_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            q_next    = {q_reg[Q_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

// File: design/aocs_convert.sv
// aocs_convert: one conversion lane: volume, rational soft clip, fade and full-scale output
// depends on aocs_pkg, aocs_serial_mult and aocs_serial_div

module aocs_convert import aocs_pkg::*; #(
    parameter int OUT_W = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [GAIN_W-1:0]        vol_gain,
    input  logic [GAIN_W-1:0]        fade_gain,
    output lane_status_t             status,
    output logic signed [OUT_W-1:0]  value
);

    localparam int K     = OUT_W - 1;           // full scale is 2^K - 1
    localparam int HI_W  = VHI_W + K;
    localparam int LO_W  = VLO_W + K;
    localparam int SUM_W = HI_W + 1;
    localparam int R_W   = SUM_W - VLO_W;

    lane_state_t state_reg, state_next;

    logic                    neg_reg, neg_next;
    logic                    clip_reg, clip_next;
    logic [GAIN_W-1:0]       fade_reg, fade_next;
    logic [A_W-1:0]          a_reg, a_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [V_W-1:0]          v_reg, v_next;
    logic [HI_W-1:0]         hi_reg, hi_next;
    logic [K-1:0]            lo_reg, lo_next;
    logic signed [OUT_W-1:0] value_reg, value_next;

    logic              mul_start, mul_busy;
    logic [MC_W-1:0]   mul_mcand;
    logic [ML_W-1:0]   mul_mlier;
    logic [PROD_W-1:0] mul_product;
    logic              div_start, div_busy;
    logic [Q_W-1:0]    div_quotient;

    logic [SAMPLE_W-1:0] sample_u;
    logic [MAG_W-1:0]    mag;
    logic [A_W-1:0]      b_val;
    logic [VHI_W-1:0]    v_hi;
    logic [VLO_W-1:0]    v_lo;
    logic [HI_W-1:0]     hi_full;
    logic [LO_W-1:0]     lo_full;
    logic [SUM_W-1:0]    sum;
    logic [R_W-1:0]      r_val;
    logic [K-1:0]        r_sat;
    logic [OUT_W-1:0]    mag_o;

    aocs_serial_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mlier   (mul_mlier),
        .busy    (mul_busy),
        .product (mul_product)
    );

    aocs_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (mul_product),
        .den      (den_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    assign sample_u = sample;
    assign mag      = sample_u[SAMPLE_W-1] ? (MAG_W'(0) - sample_u) : sample_u;
    assign b_val    = a_reg - OFFSET_Q23;

    // times (2^K - 1) as a shift and subtract, low part truncated as in the split product
    assign v_hi    = v_reg[V_W-1:VLO_W];
    assign v_lo    = v_reg[VLO_W-1:0];
    assign hi_full = {v_hi, {K{1'b0}}} - HI_W'(v_hi);
    assign lo_full = {v_lo, {K{1'b0}}} - LO_W'(v_lo);

    assign sum   = SUM_W'(hi_reg) + SUM_W'(lo_reg);
    assign r_val = sum[SUM_W-1:VLO_W];
    assign r_sat = (r_val > {2'b00, {K{1'b1}}}) ? {K{1'b1}} : r_val[K-1:0];
    assign mag_o = {1'b0, r_sat};

    always_comb begin
        state_next = state_reg;
        neg_next   = neg_reg;
        clip_next  = clip_reg;
        fade_next  = fade_reg;
        a_next     = a_reg;
        den_next   = den_reg;
        v_next     = v_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        value_next = value_reg;
        mul_start  = 1'b0;
        mul_mcand  = '0;
        mul_mlier  = '0;
        div_start  = 1'b0;
        unique case (state_reg)
            LANE_IDLE: begin
                if (start) begin
                    neg_next   = sample_u[SAMPLE_W-1];
                    fade_next  = fade_gain;
                    clip_next  = 1'b0;
                    mul_start  = 1'b1;
                    mul_mcand  = MC_W'(mag);
                    mul_mlier  = ML_W'(vol_gain);
                    state_next = LANE_MUL_VOL;
                end
            end
            LANE_MUL_VOL: begin
                if (!mul_busy) begin
                    a_next     = mul_product[VOL_SHIFT +: A_W];
                    state_next = LANE_KNEE;
                end
            end
            LANE_KNEE: begin
                mul_start = 1'b1;
                if (a_reg > KNEE_Q23) begin
                    clip_next  = 1'b1;
                    den_next   = DEN_W'(b_val) + SOFT_Q23;
                    mul_mcand  = MC_W'(b_val);
                    mul_mlier  = CEIL_Q23;
                    state_next = LANE_MUL_CEIL;
                end else begin
                    // below the knee the magnitude passes straight to the fade
                    mul_mcand  = MC_W'(a_reg[C_W-1:0]);
                    mul_mlier  = ML_W'(fade_reg);
                    state_next = LANE_MUL_FADE;
                end
            end
            LANE_MUL_CEIL: begin
                if (!mul_busy) begin
                    div_start  = 1'b1;
                    state_next = LANE_DIV;
                end
            end
            LANE_DIV: begin
                if (!div_busy) begin
                    mul_start  = 1'b1;
                    mul_mcand  = MC_W'(div_quotient);
                    mul_mlier  = ML_W'(fade_reg);
                    state_next = LANE_MUL_FADE;
                end
            end
            LANE_MUL_FADE: begin
                if (!mul_busy) begin
                    v_next     = mul_product[V_W-1:0];
                    state_next = LANE_SCALE_MUL;
                end
            end
            LANE_SCALE_MUL: begin
                hi_next    = hi_full;
                lo_next    = lo_full[LO_W-1:VLO_W];
                state_next = LANE_SCALE_SUM;
            end
            LANE_SCALE_SUM: begin
                value_next = neg_reg ? (OUT_W'(0) - mag_o) : mag_o;
                state_next = LANE_IDLE;
            end
            default: state_next = LANE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LANE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg   <= neg_next;
        clip_reg  <= clip_next;
        fade_reg  <= fade_next;
        a_reg     <= a_next;
        den_reg   <= den_next;
        v_reg     <= v_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        value_reg <= value_next;
    end

    assign status.busy = (state_reg != LANE_IDLE);
    assign status.clip = clip_reg;
    assign value       = value_reg;

endmodule

// File: design/aocs_peak_meter.sv
// aocs_peak_meter: windowed peak of the raw left magnitude driving the level led
// depends on aocs_pkg for the peak width and threshold

module aocs_peak_meter import aocs_pkg::*; #(
    parameter int WINDOW_BITS = 9
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       strobe,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       led
);

    logic [PEAK_W-1:0]      peak_reg;
    logic [WINDOW_BITS-1:0] count_reg;
    logic                   led_reg;

    logic [SAMPLE_W-1:0]    sample_u;
    logic [MAG_W-1:0]       mag;
    logic [PEAK_W-1:0]      mag_sat;
    logic [PEAK_W-1:0]      peak_upd;
    logic [WINDOW_BITS-1:0] count_inc;

    assign sample_u  = sample;
    assign mag       = sample_u[SAMPLE_W-1] ? (MAG_W'(0) - sample_u) : sample_u;
    // full negative input does not fit the peak register
    assign mag_sat   = mag[MAG_W-1] ? {PEAK_W{1'b1}} : mag[PEAK_W-1:0];
    assign peak_upd  = (mag_sat > peak_reg) ? mag_sat : peak_reg;
    assign count_inc = count_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg  <= '0;
            count_reg <= '0;
            led_reg   <= 1'b0;
        end else if (strobe) begin
            count_reg <= count_inc;
            if (count_inc == '0) begin
                led_reg  <= (peak_upd > LED_Q23);
                peak_reg <= '0;
            end else begin
                peak_reg <= peak_upd;
            end
        end
    end

    assign led = led_reg;

endmodule
